// ===== rtl/vag_pkg.sv =====
// ----------------------------------------------------------------------------
// vag_pkg: shared definitions for the VAG ADPCM decoder
// Frame layout, flag codes, the predictor coefficient table, the fixed-point
// history format, and the structs that pass between the decoder stages.
// ----------------------------------------------------------------------------
`default_nettype none

package vag_pkg;

  // Fixed-point history format: number of fraction bits.
  localparam int HIST_FRAC_BITS   = 12;
  localparam int FRAME_DATA_BYTES = 14;
  localparam int FRAME_LEN        = FRAME_DATA_BYTES + 2;
  localparam int FPOS_W           = $clog2(FRAME_LEN);

  // A nibble is scaled by 4096 before the shift.
  localparam int NIB_SCALE_BITS = 12;
  localparam int BASE_W         = 4 + NIB_SCALE_BITS;

  // Byte positions within a frame.
  localparam logic [FPOS_W-1:0] POS_HEADER = FPOS_W'(0);
  localparam logic [FPOS_W-1:0] POS_FLAG   = FPOS_W'(1);
  localparam logic [FPOS_W-1:0] POS_LAST   = FPOS_W'(FRAME_LEN - 1);

  // Flag byte codes.
  localparam logic [7:0] FLAG_END        = 8'h07;
  localparam logic [7:0] FLAG_LOOP_START = 8'h06;
  localparam logic [7:0] FLAG_LOOP_END   = 8'h03;

  // Predictor arithmetic widths.
  localparam int HIST_W   = 32;
  localparam int COEF_W   = 8;
  localparam int COEF_FRAC = 6;
  localparam int PROD_W   = HIST_W + COEF_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int PRED_W   = ACC_W - COEF_FRAC;
  localparam int BSH_W    = BASE_W + HIST_FRAC_BITS;
  localparam int V_W      = ((BSH_W > PRED_W) ? BSH_W : PRED_W) + 1;

  localparam logic [HIST_W-1:0] HIST_MAX = 32'h7FFF_FFFF;
  localparam logic [HIST_W-1:0] HIST_MIN = 32'h8000_0000;
  localparam logic [15:0]       SMP_MAX  = 16'h7FFF;
  localparam logic [15:0]       SMP_MIN  = 16'h8000;

  // Number of the highest valid predictor; others use zero coefficients.
  localparam logic [3:0] PRED_TOP = 4'd4;

  // Command queue between front and back, and result queue at the output.
  // Depths are powers of two so the pointers wrap naturally.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Configuration port.
  localparam int          PADDR_W          = 3;
  localparam int          REG_IDX_W        = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLED = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_START = 2'd1,
    MARK_END   = 2'd2
  } mark_t;

  // One data byte with everything the sample engine needs to decode it.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] shift;
    logic [2:0] pred;
    logic       restart;
    mark_t      mark;
  } cmd_t;

  // One sample in history format, before rounding.
  typedef struct packed {
    logic [HIST_W-1:0] hist;
    logic [31:0]       index;
    logic              start_mark;
    logic              end_mark;
  } res_t;

  // One finished result item.
  typedef struct packed {
    logic [15:0] sample;
    logic [31:0] index;
    logic        start_mark;
    logic        end_mark;
  } out_t;

  function automatic logic signed [COEF_W-1:0] coef_newest(input logic [2:0] p);
    logic signed [COEF_W-1:0] k;
    case (p)
      3'd1:    k = 8'sd60;
      3'd2:    k = 8'sd115;
      3'd3:    k = 8'sd98;
      3'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_older(input logic [2:0] p);
    logic signed [COEF_W-1:0] k;
    case (p)
      3'd2:    k = -8'sd52;
      3'd3:    k = -8'sd55;
      3'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vag_front.sv =====
// ----------------------------------------------------------------------------
// vag_front: frame parser and command queue
// Tracks the byte position within a frame, latches the header and flag
// bytes, and queues each data byte as a command for the sample engine.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_front
  import vag_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] stream_byte,
  input  wire logic       stream_start,
  input  wire logic       loop_enabled,
  output logic            full,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);

  logic [FPOS_W-1:0] frame_position, frame_position_next;
  logic [3:0]        shift_amount, shift_amount_next;
  logic [3:0]        predictor_index, predictor_index_next;
  mark_t             pending_mark, pending_mark_next;
  logic              stopped, stopped_next;
  logic              restart_pending, restart_pending_next;

  cmd_t                  q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;

  logic              accept;
  logic              data_push;
  logic [FPOS_W-1:0] pos;
  cmd_t              new_cmd;

  assign full      = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;

  always_comb begin
    frame_position_next  = frame_position;
    shift_amount_next    = shift_amount;
    predictor_index_next = predictor_index;
    pending_mark_next    = pending_mark;
    stopped_next         = stopped;
    restart_pending_next = restart_pending;
    data_push            = 1'b0;
    pos                  = stream_start ? POS_HEADER : frame_position;

    if (accept && stream_start) begin
      stopped_next         = 1'b0;
      pending_mark_next    = MARK_NONE;
      restart_pending_next = 1'b1;
    end

    if (accept && (stream_start || !stopped)) begin
      frame_position_next = (pos == POS_LAST) ? POS_HEADER : pos + FPOS_W'(1);
      case (pos)
        POS_HEADER: begin
          shift_amount_next    = stream_byte[3:0];
          predictor_index_next = stream_byte[7:4];
        end
        POS_FLAG: begin
          if (stream_byte == FLAG_END) begin
            stopped_next = 1'b1;
          end else if (loop_enabled && stream_byte == FLAG_LOOP_START) begin
            pending_mark_next = MARK_START;
          end else if (loop_enabled && stream_byte == FLAG_LOOP_END) begin
            pending_mark_next = MARK_END;
          end
        end
        default: begin
          data_push            = 1'b1;
          pending_mark_next    = MARK_NONE;
          restart_pending_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    new_cmd.data    = stream_byte;
    new_cmd.shift   = shift_amount;
    new_cmd.pred    = (predictor_index <= PRED_TOP) ? predictor_index[2:0] : 3'd0;
    new_cmd.restart = restart_pending;
    new_cmd.mark    = pending_mark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= POS_HEADER;
      shift_amount    <= '0;
      predictor_index <= '0;
      pending_mark    <= MARK_NONE;
      stopped         <= 1'b0;
      restart_pending <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      frame_position  <= frame_position_next;
      shift_amount    <= shift_amount_next;
      predictor_index <= predictor_index_next;
      pending_mark    <= pending_mark_next;
      stopped         <= stopped_next;
      restart_pending <= restart_pending_next;
      if (data_push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (data_push && !cmd_pop) begin
        count <= count + CMDQ_CNT_W'(1);
      end else if (!data_push && cmd_pop) begin
        count <= count - CMDQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vag_back.sv =====
// ----------------------------------------------------------------------------
// vag_back: sample engine
// Decodes one nibble per cycle while a command waits and the result side is
// ready, low nibble first, with the two-tap prediction from the history,
// and keeps the stream sample count.
`default_nettype none

module vag_back
  import vag_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  logic                     half;
  logic signed [HIST_W-1:0] newest, older;
  logic [31:0]              sample_count;

  logic                     fire;
  logic                     clr;
  logic [3:0]               nib;
  logic signed [HIST_W-1:0] newest_eff, older_eff;
  logic [31:0]              index_eff;
  logic signed [COEF_W-1:0] k0, k1;
  logic signed [BASE_W-1:0] base;
  logic signed [PROD_W-1:0] prod0, prod1;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PRED_W-1:0] pred;
  logic signed [V_W-1:0]    v;
  logic [V_W-32:0]          upper;
  logic [HIST_W-1:0]        v_sat;

  assign fire      = cmd_valid && res_ready;
  assign cmd_pop   = fire && half;
  assign res_valid = cmd_valid;

  always_comb begin
    nib        = half ? cmd.data[7:4] : cmd.data[3:0];
    clr        = cmd.restart && !half;
    newest_eff = clr ? '0 : newest;
    older_eff  = clr ? '0 : older;
    index_eff  = clr ? '0 : sample_count;
    k0         = coef_newest(cmd.pred);
    k1         = coef_older(cmd.pred);
    base       = $signed({nib, {NIB_SCALE_BITS{1'b0}}}) >>> cmd.shift;
    prod0      = PROD_W'(newest_eff) * PROD_W'(k0);
    prod1      = PROD_W'(older_eff) * PROD_W'(k1);
    acc        = ACC_W'(prod0) + ACC_W'(prod1);
    pred       = PRED_W'(acc >>> COEF_FRAC);
    v          = (V_W'(base) <<< HIST_FRAC_BITS) + V_W'(pred);
    // Saturate to 32 bits when the top bits disagree with the sign.
    upper      = v[V_W-1:31];
    if ((&upper) || !(|upper)) begin
      v_sat = v[HIST_W-1:0];
    end else begin
      v_sat = v[V_W-1] ? HIST_MIN : HIST_MAX;
    end
  end

  always_comb begin
    res.hist       = v_sat;
    res.index      = index_eff;
    res.start_mark = !half && (cmd.mark == MARK_START);
    res.end_mark   = !half && (cmd.mark == MARK_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half         <= 1'b0;
      newest       <= '0;
      older        <= '0;
      sample_count <= '0;
    end else if (fire) begin
      half         <= !half;
      older        <= newest_eff;
      newest       <= $signed(v_sat);
      sample_count <= index_eff + 32'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vag_outq.sv =====
// ----------------------------------------------------------------------------
// vag_outq: rounding stage and result queue
// Rounds the history value half away from zero, saturates it to 16 bits,
// and holds finished items until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_outq
  import vag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire res_t        res,
  output logic             res_ready,
  input  wire logic        pop,
  output logic             empty,
  output out_t             head
);

  localparam int MAG_W  = HIST_W + 1;
  localparam int RSUM_W = MAG_W + 1;
  localparam logic [RSUM_W-1:0] ROUND_HALF = RSUM_W'(1) << (HIST_FRAC_BITS - 1);

  logic                  stage_valid;
  res_t                  stage;
  out_t                  q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;

  logic                   q_full;
  logic                   stage_move;
  logic                   q_pop;
  logic                   neg;
  logic signed [MAG_W-1:0] vv;
  logic [MAG_W-1:0]       mag;
  logic [RSUM_W-1:0]      rsum;
  logic [RSUM_W-1:0]      rmag;
  out_t                   rounded;

  assign q_full     = (count == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign empty      = (count == '0);
  assign q_pop      = pop && !empty;
  assign stage_move = stage_valid && !q_full;
  assign res_ready  = !stage_valid || !q_full;
  assign head       = q[rd_ptr];

  always_comb begin
    neg  = stage.hist[HIST_W-1];
    vv   = MAG_W'($signed(stage.hist));
    mag  = neg ? MAG_W'(-vv) : MAG_W'(vv);
    rsum = RSUM_W'(mag) + ROUND_HALF;
    rmag = rsum >> HIST_FRAC_BITS;
    if (!neg) begin
      rounded.sample = (rmag > RSUM_W'(SMP_MAX)) ? SMP_MAX : rmag[15:0];
    end else begin
      rounded.sample = (rmag > RSUM_W'(SMP_MIN)) ? SMP_MIN : 16'(~rmag[15:0] + 16'd1);
    end
    rounded.index      = stage.index;
    rounded.start_mark = stage.start_mark;
    rounded.end_mark   = stage.end_mark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      if (res_ready) begin
        stage_valid <= res_valid;
      end
      if (stage_move) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      if (stage_move && !q_pop) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (!stage_move && q_pop) begin
        count <= count - OUTQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      stage <= res;
    end
    if (stage_move) begin
      q[wr_ptr] <= rounded;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vag_adpcm_decoder.sv =====
// ----------------------------------------------------------------------------
// vag_adpcm_decoder: PlayStation VAG ADPCM stream decoder
// Turns a byte stream of 16-byte VAG frames into signed 16-bit PCM samples.
// ----------------------------------------------------------------------------
//
// The input side looks like a queue: an item (one stream byte plus the
// stream_start flag) is taken at each rising edge with push high and full
// low. The result side also looks like a queue: while empty is low the oldest
// decoded sample, its index and its loop marks sit on the output ports, and
// the item is taken at an edge with pop high.
//
// Header and flag bytes yield nothing; each of the 14 data bytes of a frame
// yields two items, low nibble first, by way of the command queue, the
// sample engine, the staging register and the output queue. The sample
// engine produces one sample per cycle while the result side is ready,
// because each sample depends on the history left by the one before; the
// front takes header and flag bytes and buffers up to two data bytes, so
// bursts are taken one byte per cycle until that queue fills.
//
// When the receiver stalls, results collect in a four-entry output queue and
// a staging register, then the sample engine and the byte queue stop in turn
// and full rises. Nothing is lost. Reset clears the framing state, history,
// sample count, queues and the loop_enabled register. The APB port holds
// loop_enabled at address 0 and should be written only while the block idles.
//
`default_nettype none

module vag_adpcm_decoder
  import vag_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Stream byte channel.
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         stream_byte,
  input  wire logic               stream_start,
  // Result channel.
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      sample,
  output logic [31:0]             sample_index,
  output logic                    loop_start_mark,
  output logic                    loop_end_mark,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic loop_enabled;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;
  out_t head;

  // Registers are decoded on the word index; byte lanes within a word alias.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enabled <= 1'b0;
    end else if (psel && penable && pwrite &&
                 paddr[PADDR_W-1:2] == REG_LOOP_ENABLED) begin
      loop_enabled <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_LOOP_ENABLED) begin
      prdata = {31'd0, loop_enabled};
    end else begin
      prdata = '0;
    end
  end

  // Front: frame parsing and the command queue.
  vag_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .stream_byte  (stream_byte),
    .stream_start (stream_start),
    .loop_enabled (loop_enabled),
    .full         (full),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: one sample per cycle through the prediction loop while the result side is ready.
  vag_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Rounding and the result queue.
  vag_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign sample          = $signed(head.sample);
  assign sample_index    = head.index;
  assign loop_start_mark = head.start_mark;
  assign loop_end_mark   = head.end_mark;

endmodule

`default_nettype wire

// ===== rtl/vag_checker.sv =====
// ----------------------------------------------------------------------------
// vag_checker: port-level checks for the VAG ADPCM decoder
// Watches the top-level ports and flags behavior the decoder must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [15:0] sample,
  input wire logic [31:0]        sample_index,
  input wire logic               loop_start_mark,
  input wire logic               loop_end_mark,
  input wire logic               pready
);

  // A waiting item must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sample) && $stable(sample_index)))
    else $error("waiting result item changed before it was taken");

  // Both queues come out of reset empty.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A sample is never both a loop start and a loop end.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(loop_start_mark && loop_end_mark))
    else $error("result item carries both loop marks");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind vag_adpcm_decoder vag_checker u_vag_checker (.*);

`default_nettype wire

// ===== tb/vag_adpcm_decoder_test.sv =====
// ----------------------------------------------------------------------------
// vag_adpcm_decoder_test: self-checking testbench for the VAG ADPCM decoder
// Streams directed and random VAG frames into the decoder, predicts every
// decoded sample with an independent fixed-point model, and compares each
// item taken from the result queue against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_adpcm_decoder_test;
  import vag_pkg::*;

  // The watchdog gives up after this many cycles in which no item moves on
  // either side. The longest legal quiet stretch is the receiver hold-off.
  localparam int STALL_LIMIT   = 4000;
  // Cycles to wait after the last expected item, so that header and flag
  // bytes still in flight are done before a register write or the end.
  localparam int SETTLE_CYCLES = 10;
  // Length of the receiver hold-off, counted in cycles by the receiver.
  localparam int HOLD_CYCLES   = 200;
  // A flag byte value that carries no meaning.
  localparam logic [7:0] FLAG_NONE = 8'h00;

  typedef struct {
    logic [15:0] smp;
    logic [31:0] idx;
    logic        start_m;
    logic        end_m;
  } decoded_sample_t;

  // Every input starts at a known value.
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              push         = 1'b0;
  logic [7:0]        stream_byte  = 8'h00;
  logic              stream_start = 1'b0;
  logic              pop          = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata       = '0;

  logic              full;
  logic              empty;
  logic signed [15:0] sample;
  logic [31:0]       sample_index;
  logic              loop_start_mark;
  logic              loop_end_mark;
  logic [31:0]       prdata;
  logic              pready;

  vag_adpcm_decoder DUT (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .stream_byte     (stream_byte),
    .stream_start    (stream_start),
    .empty           (empty),
    .pop             (pop),
    .sample          (sample),
    .sample_index    (sample_index),
    .loop_start_mark (loop_start_mark),
    .loop_end_mark   (loop_end_mark),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shared test state. The idle percentages say in how many cycles of a
  // hundred each side sits idle; hold_request starts a receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int          error_count   = 0;

  decoded_sample_t expected_samples[$];

  // --------------------------------------------------------------------------
  // Decoder model. It mirrors the block's state and configuration and is
  // advanced once for every item that the block accepts.
  // --------------------------------------------------------------------------
  logic        loop_en_q   = 1'b0;
  logic [3:0]  frame_pos_q = '0;
  logic [3:0]  shift_q     = '0;
  logic [3:0]  pred_q      = '0;
  mark_t       mark_q      = MARK_NONE;
  logic        stopped_q   = 1'b0;
  int          hist_new_q  = 0;
  int          hist_old_q  = 0;
  logic [31:0] count_q     = '0;
  // Set when the last accepted byte was decoded rather than ignored.
  bit          byte_was_live = 1'b0;

  // Coefficients of the two-tap predictor in 64ths. Predictors above four
  // fall to the default arm and get zero for both taps.
  function automatic longint tap_newest(input logic [3:0] p);
    case (p)
      4'd1:    return 60;
      4'd2:    return 115;
      4'd3:    return 98;
      4'd4:    return 122;
      default: return 0;
    endcase
  endfunction

  function automatic longint tap_older(input logic [3:0] p);
    case (p)
      4'd2:    return -52;
      4'd3:    return -55;
      4'd4:    return -60;
      default: return 0;
    endcase
  endfunction

  // Decodes one nibble and advances the history. The shift of the scaled
  // nibble and the prediction both round toward minus infinity, which is
  // exactly what an arithmetic right shift does.
  function automatic logic [15:0] decode_nibble(input logic [3:0] nib);
    longint nib_val;
    longint scaled;
    longint acc;
    longint hist;
    longint rounded;
    longint half;
    nib_val = nib[3] ? longint'(nib) - 16 : longint'(nib);
    scaled  = (nib_val * 4096) >>> shift_q;
    acc     = longint'(hist_new_q) * tap_newest(pred_q)
            + longint'(hist_old_q) * tap_older(pred_q);
    hist    = (scaled <<< HIST_FRAC_BITS) + (acc >>> 6);
    if (hist > 64'sd2147483647) hist = 64'sd2147483647;
    if (hist < -64'sd2147483648) hist = -64'sd2147483648;
    hist_old_q = hist_new_q;
    hist_new_q = int'(hist);
    // Round half away from zero, then clip to 16 bits.
    half = longint'(1) <<< (HIST_FRAC_BITS - 1);
    if (hist >= 0) rounded = (hist + half) >>> HIST_FRAC_BITS;
    else rounded = -((-hist + half) >>> HIST_FRAC_BITS);
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    return rounded[15:0];
  endfunction

  function automatic void queue_decoded(input logic [3:0] nib);
    decoded_sample_t ds;
    ds.smp     = decode_nibble(nib);
    ds.idx     = count_q;
    ds.start_m = (mark_q == MARK_START);
    ds.end_m   = (mark_q == MARK_END);
    mark_q     = MARK_NONE;
    count_q    = count_q + 32'd1;
    expected_samples = {expected_samples, ds};
  endfunction

  // Advances the model by one accepted item and queues the samples it yields.
  function automatic void predict_samples(input logic [7:0] b, input logic st);
    logic [3:0] pos;
    if (st) begin
      hist_new_q  = 0;
      hist_old_q  = 0;
      frame_pos_q = '0;
      count_q     = '0;
      mark_q      = MARK_NONE;
      stopped_q   = 1'b0;
    end
    byte_was_live = !stopped_q;
    if (stopped_q) return;
    pos         = frame_pos_q;
    frame_pos_q = (pos == POS_LAST) ? POS_HEADER : pos + 4'd1;
    if (pos == POS_HEADER) begin
      shift_q = b[3:0];
      pred_q  = b[7:4];
    end else if (pos == POS_FLAG) begin
      if (b == FLAG_END) stopped_q = 1'b1;
      else if (loop_en_q && b == FLAG_LOOP_START) mark_q = MARK_START;
      else if (loop_en_q && b == FLAG_LOOP_END) mark_q = MARK_END;
    end else begin
      // Low nibble first, then high nibble.
      queue_decoded(b[3:0]);
      queue_decoded(b[7:4]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, receiver with checker, and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver samples the outputs at each rising edge, before the block's
  // own updates of that edge land, and then decides pop for the next edge.
  // A hold-off keeps pop low for a fixed count of its own cycles.
  initial begin
    decoded_sample_t ds;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_samples.size() == 0) begin
          $error("result item with no expected sample: sample %0d index %0d",
                 sample, sample_index);
          error_count++;
        end else begin
          ds = expected_samples.pop_front();
          if (sample !== ds.smp) begin
            $error("sample: expected %0d, actual %0d", $signed(ds.smp), sample);
            error_count++;
          end
          if (sample_index !== ds.idx) begin
            $error("sample_index: expected %0d, actual %0d", ds.idx, sample_index);
            error_count++;
          end
          if (loop_start_mark !== ds.start_m) begin
            $error("loop_start_mark: expected %0b, actual %0b",
                   ds.start_m, loop_start_mark);
            error_count++;
          end
          if (loop_end_mark !== ds.end_m) begin
            $error("loop_end_mark: expected %0b, actual %0b", ds.end_m, loop_end_mark);
            error_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Counts cycles in which no item moves on either side.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("vag_adpcm_decoder: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks.
  // --------------------------------------------------------------------------

  // Offers one item and returns at the edge where the block takes it. Push
  // stays high on return so that back-to-back items need no extra cycle.
  task automatic send_byte(input logic [7:0] b, input logic st);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push         <= 1'b1;
    stream_byte  <= b;
    stream_start <= st;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_samples(b, st);
  endtask

  // Stops offering items and waits until every expected sample has arrived,
  // then a little longer for bytes that yield nothing.
  task automatic wait_all_results();
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes loop_enabled through the APB port; the block must be idle.
  task automatic write_loop_enabled(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_LOOP_ENABLED) << 2;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    loop_en_q = value;
  endtask

  // Sends well-formed frames with random content, with the odd mid-frame
  // restart and end-of-playback flag as noise. Only items that the block
  // decodes count toward the total; after a stop a restart follows soon.
  task automatic send_random_frames(input int count);
    int         sent;
    int         pos;
    int         pick;
    logic [7:0] b;
    logic       st;
    sent = 0;
    pos  = 0;
    while (sent < count) begin
      st = (sent == 0 && pos == 0) || ($urandom_range(99) < 2) ||
           (stopped_q && $urandom_range(99) < 40);
      if (st) pos = 0;
      if (pos == 0) begin
        b[3:0] = ($urandom_range(99) < 85) ? 4'($urandom_range(12))
                                           : 4'($urandom_range(15, 13));
        b[7:4] = ($urandom_range(99) < 85) ? 4'($urandom_range(4))
                                           : 4'($urandom_range(15, 5));
      end else if (pos == 1) begin
        pick = $urandom_range(99);
        if (pick < 20) b = FLAG_LOOP_START;
        else if (pick < 40) b = FLAG_LOOP_END;
        else if (pick < 43) b = FLAG_END;
        else if (pick < 60) b = FLAG_NONE;
        else b = 8'($urandom_range(255));
      end else begin
        b = 8'($urandom_range(255));
      end
      send_byte(b, st);
      if (byte_was_live) sent++;
      pos = (pos == FRAME_LEN - 1) ? 0 : pos + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // A plain frame with the strongest predictor and no shift, so the output
  // clips at the top of the 16-bit range.
  task automatic test_plain_frame();
    send_byte(8'h40, 1'b1);
    send_byte(FLAG_NONE, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'hF0, 1'b0);
    wait_all_results();
  endtask

  // Shifts of thirteen and above, predictors above four, an unknown flag,
  // and a restart in the middle of a frame.
  task automatic test_shift_and_predictor_corners();
    send_byte(8'hFD, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'h5F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    wait_all_results();
  endtask

  // Loop start and loop end flags mark the first sample of their frame only
  // while looping is enabled.
  task automatic test_loop_flags();
    write_loop_enabled(1'b1);
    send_byte(8'h21, 1'b1);
    send_byte(FLAG_LOOP_START, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h31, 1'b1);
    send_byte(FLAG_LOOP_END, 1'b0);
    send_byte(8'h56, 1'b0);
    wait_all_results();
    write_loop_enabled(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(FLAG_LOOP_START, 1'b0);
    send_byte(8'h9A, 1'b0);
    wait_all_results();
  endtask

  // The end flag silences the block until the next stream start.
  task automatic test_end_of_playback();
    send_byte(8'h10, 1'b1);
    send_byte(FLAG_END, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h30, 1'b1);
    send_byte(FLAG_NONE, 1'b0);
    send_byte(8'hEF, 1'b0);
    wait_all_results();
  endtask

  // The receiver holds off while the sender keeps offering bytes, so the
  // result queue fills, the engine stops and full rises.
  task automatic test_receiver_holdoff();
    hold_request = 1'b1;
    send_random_frames(48);
    wait_all_results();
  endtask

  // One random phase at the given idling. Halfway the sender pauses until
  // every expected sample has come, then the stream goes on.
  task automatic test_random_traffic(input int unsigned snd_pct,
                                     input int unsigned rcv_pct,
                                     input logic loop_on, input int count);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_loop_enabled(loop_on);
    send_random_frames(count / 2);
    wait_all_results();
    send_random_frames(count - count / 2);
    wait_all_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 53;
    write_loop_enabled(1'b0);
    test_plain_frame();
    test_shift_and_predictor_corners();
    test_loop_flags();
    test_end_of_playback();
    test_receiver_holdoff();

    test_random_traffic(29, 53, 1'b1, 180);
    test_random_traffic(53, 29, 1'b0, 180);
    test_random_traffic(0, 0, 1'b1, 180);

    if (error_count == 0) begin
      $display("vag_adpcm_decoder: match");
    end else begin
      $display("vag_adpcm_decoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
